FILE: design/stencil_neighbor_list_assert.svh
// ----------------------------------------------------------------------------
// stencil_neighbor_list assertion macros
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef STENCIL_NEIGHBOR_LIST_ASSERT_SVH
`define STENCIL_NEIGHBOR_LIST_ASSERT_SVH

// same-cycle implication
`define SNL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SNL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/snl_pkg.sv
// ----------------------------------------------------------------------------
// snl_pkg
// Shared types and constants of the stencil neighbor list block.
// ----------------------------------------------------------------------------
`default_nettype none

package snl_pkg;

	localparam int SIZE_W   = 11;
	localparam int LAYER_W  = 10;
	localparam int PLANE_W  = 2 * SIZE_W;
	localparam int ID_W     = 30;
	localparam int OUT_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int NCAND    = 9;
	localparam int CAND_IDX_W = 4;
	localparam int QDEPTH   = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REGULAR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRISM   = 3'd4;

	// candidate positions in run order
	localparam logic [CAND_IDX_W-1:0] CAND_PRISM_BACK = 4'd0;
	localparam logic [CAND_IDX_W-1:0] CAND_Z_MINUS    = 4'd1;
	localparam logic [CAND_IDX_W-1:0] CAND_Y_MINUS    = 4'd2;
	localparam logic [CAND_IDX_W-1:0] CAND_X_MINUS    = 4'd3;
	localparam logic [CAND_IDX_W-1:0] CAND_SELF       = 4'd4;
	localparam logic [CAND_IDX_W-1:0] CAND_X_PLUS     = 4'd5;
	localparam logic [CAND_IDX_W-1:0] CAND_Y_PLUS     = 4'd6;
	localparam logic [CAND_IDX_W-1:0] CAND_Z_PLUS     = 4'd7;
	localparam logic [CAND_IDX_W-1:0] CAND_PRISM_FWD  = 4'd8;

	typedef struct packed {
		logic [SIZE_W-1:0]  size_x;
		logic [SIZE_W-1:0]  size_y;
		logic [SIZE_W-1:0]  size_z;
		logic [LAYER_W-1:0] regular;
		logic [LAYER_W-1:0] prism;
		logic [PLANE_W-1:0] plane;
	} snl_cfg_t;

	typedef struct packed {
		logic [ID_W-1:0]  base;
		logic [NCAND-1:0] mask;
	} snl_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} snl_qstat_t;

endpackage

`default_nettype wire

FILE: design/snl_fifo.sv
// ----------------------------------------------------------------------------
// snl_fifo
// Short register queue between the classify front and the emit back.
// ----------------------------------------------------------------------------
`default_nettype none

module snl_fifo (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	input  wire snl_pkg::snl_entry_t push_data,
	input  wire                      pop,
	output snl_pkg::snl_entry_t      pop_data,
	output snl_pkg::snl_qstat_t      stat
);

	localparam int PW = (snl_pkg::QDEPTH > 1) ? $clog2(snl_pkg::QDEPTH) : 1;

	snl_pkg::snl_entry_t       mem_q [snl_pkg::QDEPTH];
	logic [PW-1:0]             wr_ptr_q;
	logic [PW-1:0]             rd_ptr_q;
	logic [PW:0]               count_q;

	assign pop_data   = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == (PW+1)'(snl_pkg::QDEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(snl_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(snl_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/snl_front.sv
// ----------------------------------------------------------------------------
// snl_front
// Accepts a grid point, finds its layer phase with a two-bit-per-cycle
// remainder unit, forms the base id and the mask of in-mesh candidates.
// ----------------------------------------------------------------------------
`default_nettype none

module snl_front #(
	parameter int COORD_BITS = 10
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire snl_pkg::snl_cfg_t   cfg,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire [COORD_BITS-1:0]     coord_x,
	input  wire [COORD_BITS-1:0]     coord_y,
	input  wire [COORD_BITS-1:0]     coord_z,
	input  wire snl_pkg::snl_qstat_t qstat,
	output logic                     push,
	output snl_pkg::snl_entry_t      push_data
);

	localparam int ZW2 = 2 * ((COORD_BITS + 1) / 2);
	localparam int K   = ZW2 / 2;
	localparam int CW  = (K > 1) ? $clog2(K) : 1;
	localparam int RW  = ((COORD_BITS > snl_pkg::SIZE_W) ? COORD_BITS : snl_pkg::SIZE_W) + 1;
	localparam int ID_W = snl_pkg::ID_W;

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_PUSH} state_t;

	typedef struct packed {
		logic lo;
		logic mid;
		logic hi;
	} axis_t;

	state_t                state_q;
	logic [CW-1:0]         cnt_q;
	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;
	logic [COORD_BITS-1:0] z_q;
	logic [ZW2-1:0]        zsh_q;
	logic [RW-1:0]         rem_q;
	logic [ID_W-1:0]       prod_z_s1;
	logic [ID_W-1:0]       prod_y_s1;

	logic [RW-1:0]         period;
	logic [RW-1:0]         r1;
	logic [RW-1:0]         r2;
	logic [RW-1:0]         rem_prev;
	logic                  link_back;
	logic                  link_fwd;
	logic                  accept;
	axis_t                 ax;
	axis_t                 ay;
	axis_t                 az;

	function automatic axis_t axis_flags(input logic [COORD_BITS-1:0] c,
			input logic [snl_pkg::SIZE_W-1:0] s);
		axis_t f;
		logic [RW-1:0] ce;
		logic [RW-1:0] se;
		ce    = RW'(c);
		se    = RW'(s);
		f.lo  = (c != '0) && ((ce - 1'b1) < se);
		f.mid = (ce < se);
		f.hi  = ((ce + 1'b1) < se);
		return f;
	endfunction

	assign period = RW'(cfg.regular) + RW'(cfg.prism);

	always_comb begin
		r1 = {rem_q[RW-2:0], zsh_q[ZW2-1]};
		if (r1 >= period) begin
			r1 = r1 - period;
		end
		r2 = {r1[RW-2:0], zsh_q[ZW2-2]};
		if (r2 >= period) begin
			r2 = r2 - period;
		end
	end

	assign rem_prev  = (rem_q == '0) ? period - 1'b1 : rem_q - 1'b1;
	assign link_back = (cfg.prism != '0) && (z_q != '0) && (rem_prev >= RW'(cfg.regular));
	assign link_fwd  = (cfg.prism != '0) && (rem_q >= RW'(cfg.regular));

	assign ax = axis_flags(x_q, cfg.size_x);
	assign ay = axis_flags(y_q, cfg.size_y);
	assign az = axis_flags(z_q, cfg.size_z);

	always_comb begin
		push_data.base = prod_z_s1 + prod_y_s1 + ID_W'(x_q);
		push_data.mask[snl_pkg::CAND_PRISM_BACK] = link_back && ax.lo && ay.mid && az.lo;
		push_data.mask[snl_pkg::CAND_Z_MINUS]    = ax.mid && ay.mid && az.lo;
		push_data.mask[snl_pkg::CAND_Y_MINUS]    = ax.mid && ay.lo && az.mid;
		push_data.mask[snl_pkg::CAND_X_MINUS]    = ax.lo && ay.mid && az.mid;
		push_data.mask[snl_pkg::CAND_SELF]       = ax.mid && ay.mid && az.mid;
		push_data.mask[snl_pkg::CAND_X_PLUS]     = ax.hi && ay.mid && az.mid;
		push_data.mask[snl_pkg::CAND_Y_PLUS]     = ax.mid && ay.hi && az.mid;
		push_data.mask[snl_pkg::CAND_Z_PLUS]     = ax.mid && ay.mid && az.hi;
		push_data.mask[snl_pkg::CAND_PRISM_FWD]  = link_fwd && ax.hi && ay.mid && az.hi;
	end

	assign push     = (state_q == ST_PUSH) && !qstat.full;
	assign in_ready = (state_q == ST_IDLE) || push;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk) begin
		prod_z_s1 <= ID_W'(z_q) * ID_W'(cfg.plane);
		prod_y_s1 <= ID_W'(y_q) * ID_W'(cfg.size_x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			x_q     <= '0;
			y_q     <= '0;
			z_q     <= '0;
			zsh_q   <= '0;
			rem_q   <= '0;
		end else begin
			unique case (state_q) inside
				ST_IDLE, ST_PUSH: begin
					if (accept) begin
						x_q     <= coord_x;
						y_q     <= coord_y;
						z_q     <= coord_z;
						zsh_q   <= ZW2'(coord_z);
						rem_q   <= '0;
						cnt_q   <= CW'(K - 1);
						state_q <= ST_DIV;
					end else if (push) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					rem_q <= r2;
					zsh_q <= zsh_q << 2;
					if (cnt_q == '0) begin
						state_q <= ST_PUSH;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: design/snl_back.sv
// ----------------------------------------------------------------------------
// snl_back
// Walks the candidate mask of one point, one neighbor id per beat,
// into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module snl_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire snl_pkg::snl_cfg_t       cfg,
	input  wire snl_pkg::snl_qstat_t     qstat,
	input  wire snl_pkg::snl_entry_t     pop_data,
	output logic                         pop,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [snl_pkg::ID_W-1:0]     neighbor_id,
	output logic                         last
);

	localparam int ID_W  = snl_pkg::ID_W;
	localparam int NCAND = snl_pkg::NCAND;

	logic                             work_v_q;
	logic [ID_W-1:0]                  base_q;
	logic [NCAND-1:0]                 mask_q;
	logic                             out_v_q;
	logic [ID_W-1:0]                  id_q;
	logic                             last_q;

	logic [NCAND-1:0]                 pick;
	logic [NCAND-1:0]                 rest;
	logic [snl_pkg::CAND_IDX_W-1:0]   idx;
	logic [ID_W-1:0]                  delta;
	logic                             sub;
	logic [ID_W-1:0]                  id_next;
	logic                             can_emit;
	logic                             emit;
	logic                             finish;

	assign pick = mask_q & (~mask_q + 1'b1);
	assign rest = mask_q & ~pick;

	always_comb begin
		idx = '0;
		for (int i = 0; i < NCAND; i++) begin
			if (pick[i]) begin
				idx = snl_pkg::CAND_IDX_W'(i);
			end
		end
	end

	always_comb begin
		delta = '0;
		sub   = 1'b0;
		unique case (idx)
			snl_pkg::CAND_PRISM_BACK: begin
				delta = ID_W'(cfg.plane) + 1'b1;
				sub   = 1'b1;
			end
			snl_pkg::CAND_Z_MINUS: begin
				delta = ID_W'(cfg.plane);
				sub   = 1'b1;
			end
			snl_pkg::CAND_Y_MINUS: begin
				delta = ID_W'(cfg.size_x);
				sub   = 1'b1;
			end
			snl_pkg::CAND_X_MINUS: begin
				delta = ID_W'(1);
				sub   = 1'b1;
			end
			snl_pkg::CAND_SELF: begin
				delta = '0;
			end
			snl_pkg::CAND_X_PLUS: begin
				delta = ID_W'(1);
			end
			snl_pkg::CAND_Y_PLUS: begin
				delta = ID_W'(cfg.size_x);
			end
			snl_pkg::CAND_Z_PLUS: begin
				delta = ID_W'(cfg.plane);
			end
			snl_pkg::CAND_PRISM_FWD: begin
				delta = ID_W'(cfg.plane) + 1'b1;
			end
			default: begin
				delta = '0;
			end
		endcase
	end

	assign id_next  = sub ? base_q - delta : base_q + delta;
	assign can_emit = !out_v_q || out_ready;
	assign emit     = work_v_q && (mask_q != '0) && can_emit;
	assign finish   = work_v_q && ((mask_q == '0) || (can_emit && (rest == '0)));
	assign pop      = !qstat.empty && (!work_v_q || finish);

	assign out_valid   = out_v_q;
	assign neighbor_id = id_q;
	assign last        = last_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			base_q <= pop_data.base;
		end
		if (emit) begin
			id_q   <= id_next;
			last_q <= (rest == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_v_q <= 1'b0;
			mask_q   <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (pop) begin
				work_v_q <= 1'b1;
				mask_q   <= pop_data.mask;
			end else if (finish) begin
				work_v_q <= 1'b0;
			end else if (emit) begin
				mask_q <= rest;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/stencil_neighbor_list.sv
// ----------------------------------------------------------------------------
// stencil_neighbor_list
// Seven-point stencil neighbor ids of a 3-D mesh point, with optional
// prism diagonal links, as a run of beats closed by tlast.
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  tdata: coord_x, coord_y, coord_z
//   m_*       out  m_tvalid/m_tready  tdata: neighbor_id; tlast: last
//   cfg_*     in   cfg_we             cfg_index, cfg_data
//
// Input: a new point is taken only once the previous one enters the queue;
// the layer-remainder unit retires two bits per cycle.
// Output: one beat per cycle per neighbor while m_tready holds, 1 to 9
// per point; a point with no in-mesh neighbor gives no beat.
// A point's beats pass the remainder unit, the queue and the output stage.
// Reset loads the configuration defaults; a two-entry queue lets either
// side stall without stopping the other.
// ----------------------------------------------------------------------------
`default_nettype none

module stencil_neighbor_list #(
	parameter int COORD_BITS = 10
) (
	input  wire                                         clk,
	input  wire                                         arst_n,
	input  wire                                         s_tvalid,
	output logic                                        s_tready,
	// coord_x, coord_y, coord_z, zero pad
	input  wire [((3*COORD_BITS+7)/8)*8-1:0]            s_tdata,
	output logic                                        m_tvalid,
	input  wire                                         m_tready,
	// neighbor_id, zero pad
	output logic [snl_pkg::OUT_W-1:0]                   m_tdata,
	output logic                                        m_tlast,
	input  wire                                         cfg_we,
	input  wire [snl_pkg::CFG_IDX_W-1:0]                cfg_index,
	input  wire [snl_pkg::SIZE_W-1:0]                   cfg_data
);

	snl_pkg::snl_cfg_t          cfg;
	logic [snl_pkg::SIZE_W-1:0] size_x_q;
	logic [snl_pkg::SIZE_W-1:0] size_y_q;
	logic [snl_pkg::SIZE_W-1:0] size_z_q;
	logic [snl_pkg::LAYER_W-1:0] regular_q;
	logic [snl_pkg::LAYER_W-1:0] prism_q;
	logic [snl_pkg::PLANE_W-1:0] plane_q;

	snl_pkg::snl_qstat_t        qstat;
	snl_pkg::snl_entry_t        push_data;
	snl_pkg::snl_entry_t        pop_data;
	logic                       push;
	logic                       pop;
	logic [snl_pkg::ID_W-1:0]   neighbor_id;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q  <= snl_pkg::SIZE_W'(1);
			size_y_q  <= snl_pkg::SIZE_W'(1);
			size_z_q  <= snl_pkg::SIZE_W'(1);
			regular_q <= '0;
			prism_q   <= '0;
			plane_q   <= snl_pkg::PLANE_W'(1);
		end else begin
			plane_q <= snl_pkg::PLANE_W'(size_x_q) * snl_pkg::PLANE_W'(size_y_q);
			if (cfg_we) begin
				unique case (cfg_index)
					snl_pkg::REG_SIZE_X:  size_x_q  <= cfg_data;
					snl_pkg::REG_SIZE_Y:  size_y_q  <= cfg_data;
					snl_pkg::REG_SIZE_Z:  size_z_q  <= cfg_data;
					snl_pkg::REG_REGULAR: regular_q <= cfg_data[snl_pkg::LAYER_W-1:0];
					snl_pkg::REG_PRISM:   prism_q   <= cfg_data[snl_pkg::LAYER_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		cfg.size_x  = size_x_q;
		cfg.size_y  = size_y_q;
		cfg.size_z  = size_z_q;
		cfg.regular = regular_q;
		cfg.prism   = prism_q;
		cfg.plane   = plane_q;
	end

	snl_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.coord_x   (s_tdata[COORD_BITS-1:0]),
		.coord_y   (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.coord_z   (s_tdata[3*COORD_BITS-1:2*COORD_BITS]),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	snl_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (qstat)
	);

	snl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.qstat       (qstat),
		.pop_data    (pop_data),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.neighbor_id (neighbor_id),
		.last        (m_tlast)
	);

	assign m_tdata = snl_pkg::OUT_W'(neighbor_id);

endmodule

`default_nettype wire

FILE: design/snl_checker.sv
// ----------------------------------------------------------------------------
// snl_checker
// Port-level checks of the stencil neighbor list, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stencil_neighbor_list_assert.svh"

module snl_checker #(
	parameter int COORD_BITS = 10
) (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               s_tvalid,
	input wire                               s_tready,
	input wire [((3*COORD_BITS+7)/8)*8-1:0]  s_tdata,
	input wire                               m_tvalid,
	input wire                               m_tready,
	input wire [snl_pkg::OUT_W-1:0]          m_tdata,
	input wire                               m_tlast
);

	logic out_stall;
	logic pad_zero;
	logic in_stall;

	assign out_stall = m_tvalid && !m_tready;
	assign pad_zero  = (m_tdata[snl_pkg::OUT_W-1:snl_pkg::ID_W] == '0);
	assign in_stall  = s_tvalid && !s_tready;

	`SNL_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled beat changed")
	`SNL_ASSERT_NEXT(a_in_hold, clk, arst_n, in_stall,
		s_tvalid && $stable(s_tdata), "waiting input beat changed")
	`SNL_ASSERT_SAME(a_out_pad, clk, arst_n, m_tvalid, pad_zero, "tdata pad bits set")
	`SNL_ASSERT_SAME(a_idle_after_reset, clk, arst_n, !$past(arst_n), !m_tvalid,
		"beat right after reset")

endmodule

bind stencil_neighbor_list snl_checker #(
	.COORD_BITS (COORD_BITS)
) u_snl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.s_tdata   (s_tdata),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast)
);

`default_nettype wire

FILE: tb/stencil_neighbor_list_tb.sv
// ----------------------------------------------------------------------------
// stencil_neighbor_list_tb
// Sends grid points to the neighbor list block under several mesh and layer
// settings, with random gaps on both streams. A scoreboard class works out
// each point's neighbor ids and end-of-run flag, and checks every output beat
// against the oldest outstanding id in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stencil_neighbor_list_tb;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 24;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_POINTS = 21;

	typedef struct {
		logic [snl_pkg::OUT_W-1:0] data;
		logic                      last;
	} nbr_beat_t;

	class snl_scoreboard;
		logic [snl_pkg::SIZE_W-1:0]  size_x;
		logic [snl_pkg::SIZE_W-1:0]  size_y;
		logic [snl_pkg::SIZE_W-1:0]  size_z;
		logic [snl_pkg::LAYER_W-1:0] regular;
		logic [snl_pkg::LAYER_W-1:0] prism;
		nbr_beat_t                   pending_ids[$];
		int                          errors;

		function new();
			size_x  = snl_pkg::SIZE_W'(1);
			size_y  = snl_pkg::SIZE_W'(1);
			size_z  = snl_pkg::SIZE_W'(1);
			regular = '0;
			prism   = '0;
			errors  = 0;
		endfunction

		function void set_reg(logic [snl_pkg::CFG_IDX_W-1:0] idx,
			logic [snl_pkg::SIZE_W-1:0] val);
			case (idx)
				snl_pkg::REG_SIZE_X:  size_x = val;
				snl_pkg::REG_SIZE_Y:  size_y = val;
				snl_pkg::REG_SIZE_Z:  size_z = val;
				snl_pkg::REG_REGULAR: regular = val[snl_pkg::LAYER_W-1:0];
				snl_pkg::REG_PRISM:   prism = val[snl_pkg::LAYER_W-1:0];
				default: ;
			endcase
		endfunction

		function bit inside_mesh(longint x, longint y, longint z);
			return x >= 0 && x < size_x && y >= 0 && y < size_y && z >= 0 && z < size_z;
		endfunction

		function logic [snl_pkg::ID_W-1:0] linear_id(longint x, longint y, longint z);
			longint v;
			v = z * size_x * size_y + y * size_x + x;
			return v[snl_pkg::ID_W-1:0];
		endfunction

		// build the neighbor run of one accepted point
		function void note_point(logic [9:0] cx, logic [9:0] cy, logic [9:0] cz);
			int        off_x[7] = '{0, 0, -1, 0, 1, 0, 0};
			int        off_y[7] = '{0, -1, 0, 0, 0, 1, 0};
			int        off_z[7] = '{-1, 0, 0, 0, 0, 0, 1};
			longint    x, y, z, period;
			longint    cand_x[snl_pkg::NCAND];
			longint    cand_y[snl_pkg::NCAND];
			longint    cand_z[snl_pkg::NCAND];
			int        ncand;
			int        added;
			bit        link_back, link_fwd;
			nbr_beat_t beat;
			x = cx;
			y = cy;
			z = cz;
			link_back = 0;
			link_fwd = 0;
			if (prism != 0) begin
				period = longint'(regular) + longint'(prism);
				link_back = z > 0 && ((z - 1) % period) >= regular;
				link_fwd = z < longint'(size_z) - 1 && (z % period) >= regular;
			end
			ncand = 0;
			if (link_back) begin
				cand_x[ncand] = x - 1;
				cand_y[ncand] = y;
				cand_z[ncand] = z - 1;
				ncand++;
			end
			for (int l = 0; l < 7; l++) begin
				cand_x[ncand] = x + off_x[l];
				cand_y[ncand] = y + off_y[l];
				cand_z[ncand] = z + off_z[l];
				ncand++;
			end
			if (link_fwd) begin
				cand_x[ncand] = x + 1;
				cand_y[ncand] = y;
				cand_z[ncand] = z + 1;
				ncand++;
			end
			added = 0;
			for (int c = 0; c < ncand; c++) begin
				if (inside_mesh(cand_x[c], cand_y[c], cand_z[c])) begin
					beat.data = {{(snl_pkg::OUT_W-snl_pkg::ID_W){1'b0}},
						linear_id(cand_x[c], cand_y[c], cand_z[c])};
					beat.last = 1'b0;
					pending_ids.insert(pending_ids.size(), beat);
					added++;
				end
			end
			// flag the end of a non-empty run
			if (added != 0)
				pending_ids[pending_ids.size()-1].last = 1'b1;
		endfunction

		function void check_beat(logic [snl_pkg::OUT_W-1:0] data, logic last);
			nbr_beat_t want;
			if (pending_ids.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat: tdata=%h tlast=%b", data, last);
				return;
			end
			want = pending_ids.pop_front();
			if (data !== want.data) begin
				errors++;
				if (errors <= 10)
					$display("neighbor id mismatch: expected %h, got %h", want.data, data);
			end
			if (last !== want.last) begin
				errors++;
				if (errors <= 10)
					$display("tlast mismatch on id %h: expected %b, got %b",
						want.data, want.last, last);
			end
		endfunction

		function bit clean();
			if (pending_ids.size() != 0)
				$display("%0d neighbor ids never arrived", pending_ids.size());
			return errors == 0 && pending_ids.size() == 0;
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [31:0]                   s_tdata;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [snl_pkg::OUT_W-1:0]     m_tdata;
	logic                          m_tlast;
	logic                          cfg_we;
	logic [snl_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [snl_pkg::SIZE_W-1:0]    cfg_data;

	snl_scoreboard sb;
	bit            steady_send;
	bit            steady_recv;
	int            cycle_count;

	stencil_neighbor_list u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap(bit steady);
		return steady ? 0 : $urandom_range(0, 11);
	endfunction

	task automatic send_point(logic [9:0] x, logic [9:0] y, logic [9:0] z);
		int gap;
		gap = pick_gap(steady_send);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, z, y, x};
		do @(posedge clk); while (!s_tready);
		sb.note_point(x, y, z);
	endtask

	// hold the input until every outstanding id has come out
	task automatic drain_block();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending_ids.size() != 0);
	endtask

	task automatic settle_block();
		drain_block();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [snl_pkg::CFG_IDX_W-1:0] idx,
		logic [snl_pkg::SIZE_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic set_mesh(logic [snl_pkg::SIZE_W-1:0] sx, logic [snl_pkg::SIZE_W-1:0] sy,
		logic [snl_pkg::SIZE_W-1:0] sz, logic [snl_pkg::SIZE_W-1:0] reg_n,
		logic [snl_pkg::SIZE_W-1:0] prism_n);
		settle_block();
		write_reg(snl_pkg::REG_SIZE_X, sx);
		write_reg(snl_pkg::REG_SIZE_Y, sy);
		write_reg(snl_pkg::REG_SIZE_Z, sz);
		write_reg(snl_pkg::REG_REGULAR, reg_n);
		write_reg(snl_pkg::REG_PRISM, prism_n);
		// unused index, must leave the mesh alone
		write_reg(snl_pkg::CFG_IDX_W'($urandom_range(5, 7)),
			snl_pkg::SIZE_W'($urandom_range(0, 2047)));
		steady_send = ($urandom_range(0, 3) == 0);
	endtask

	function automatic logic [9:0] pick_coord(logic [snl_pkg::SIZE_W-1:0] extent);
		int top;
		if (extent == 0)
			return 10'($urandom_range(0, 1023));
		top = (extent > 1024) ? 1023 : extent - 1;
		case ($urandom_range(0, 5))
			0: return 10'd0;
			1: return 10'(top);
			default: return 10'($urandom_range(0, top));
		endcase
	endfunction

	function automatic logic [snl_pkg::SIZE_W-1:0] pick_extent();
		if ($urandom_range(0, 9) != 0)
			return snl_pkg::SIZE_W'($urandom_range(1, 8));
		case ($urandom_range(0, 4))
			0: return snl_pkg::SIZE_W'(0);
			1: return snl_pkg::SIZE_W'(1);
			2: return snl_pkg::SIZE_W'(1024);
			3: return snl_pkg::SIZE_W'(2047);
			default: return snl_pkg::SIZE_W'($urandom_range(0, 2047));
		endcase
	endfunction

	task automatic random_phase(int phase);
		logic [snl_pkg::SIZE_W-1:0] sx, sy, sz, reg_n, prism_n;
		sx = pick_extent();
		sy = pick_extent();
		sz = pick_extent();
		reg_n = ($urandom_range(0, 4) == 0) ? snl_pkg::SIZE_W'($urandom_range(0, 2047))
			: snl_pkg::SIZE_W'($urandom_range(0, 4));
		case ($urandom_range(0, 5)) inside
			0, 1: prism_n = '0;
			2: prism_n = snl_pkg::SIZE_W'($urandom_range(0, 2047));
			default: prism_n = snl_pkg::SIZE_W'($urandom_range(1, 3));
		endcase
		set_mesh(sx, sy, sz, reg_n, prism_n);
		for (int n = 0; n < PHASE_POINTS; n++) begin
			if ($urandom_range(0, 6) == 0)
				send_point(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
					10'($urandom_range(0, 1023)));
			else
				send_point(pick_coord(sx), pick_coord(sy), pick_coord(sz));
			if ((phase == 1 && n == 10) || $urandom_range(0, 39) == 0)
				drain_block();
		end
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		steady_send = 1'b0;
		steady_recv = 1'b0;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset mesh is a single point
		send_point(10'd0, 10'd0, 10'd0);
		send_point(10'd1, 10'd0, 10'd0);
		send_point(10'd1023, 10'd1023, 10'd1023);

		// small mesh, alternating plain and prism layers
		set_mesh(11'd4, 11'd3, 11'd5, 11'd1, 11'd1);
		send_point(10'd0, 10'd0, 10'd0);
		send_point(10'd3, 10'd2, 10'd4);
		send_point(10'd1, 10'd1, 10'd1);
		send_point(10'd2, 10'd1, 10'd2);
		send_point(10'd0, 10'd1, 10'd1);
		send_point(10'd3, 10'd1, 10'd2);
		send_point(10'd4, 10'd1, 10'd2);

		// largest legal mesh, every layer a prism layer
		set_mesh(11'd1024, 11'd1024, 11'd1024, 11'd0, 11'd1023);
		send_point(10'd1023, 10'd1023, 10'd1023);
		send_point(10'd0, 10'd0, 10'd0);
		send_point(10'd512, 10'd0, 10'd1022);
		send_point(10'd1, 10'd1023, 10'd1);

		// extents above range, ids wrap
		set_mesh(11'd2047, 11'd2047, 11'd2047, 11'd1023, 11'd1023);
		send_point(10'd1023, 10'd1023, 10'd1023);
		send_point(10'd1023, 10'd0, 10'd1023);
		send_point(10'd0, 10'd1023, 10'd1022);

		// zero extent, empty runs
		set_mesh(11'd0, 11'd4, 11'd4, 11'd2, 11'd3);
		send_point(10'd0, 10'd0, 10'd0);
		send_point(10'd1, 10'd1, 10'd1);
		set_mesh(11'd4, 11'd4, 11'd0, 11'd0, 11'd2);
		send_point(10'd2, 10'd2, 10'd0);

		for (int p = 0; p < RANDOM_PHASES; p++)
			random_phase(p);

		settle_block();
		if (sb.clean())
			$display("stencil_neighbor_list_tb: PASS");
		else
			$display("stencil_neighbor_list_tb: FAIL");
		$finish;
	end

	initial begin
		int gap;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			gap = pick_gap(steady_recv);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_beat(m_tdata, m_tlast);
			if ($urandom_range(0, 39) == 0)
				steady_recv = ~steady_recv;
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("stencil_neighbor_list_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
